// ===== rtl/spiral_order_scan_assert.svh =====
`ifndef SPIRAL_ORDER_SCAN_ASSERT_SVH
`define SPIRAL_ORDER_SCAN_ASSERT_SVH

// same-cycle implication
`define SOS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("spiral_order_scan check failed");

// next-cycle implication
`define SOS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("spiral_order_scan check failed");

`endif

// ===== rtl/sos_pkg.sv =====
package sos_pkg;

  localparam int MAX_DIM   = 8;
  localparam int DIM_W     = 4;
  localparam int DATA_W    = 32;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int POS_W     = $clog2(MAX_DIM);
  localparam int BND_W     = POS_W + 2;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_COLS = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic load_full;
    logic scan_last;
  } ctl_sts_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = d;
    end
    return res;
  endfunction

endpackage

// ===== rtl/sos_ram.sv =====
module sos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sos_ctrl.sv =====
module sos_ctrl import sos_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.load_full) begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/sos_datapath.sv =====
module sos_datapath import sos_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic signed [DATA_W-1:0] in_elem_value,
  input  ctl_cmd_t                cmd,
  output ctl_sts_t                sts,
  output logic                    out_valid,
  output logic signed [DATA_W-1:0] out_value,
  output logic                    out_last
);

  typedef enum logic [3:0] {
    SD_TOP    = 4'b0001,
    SD_RIGHT  = 4'b0010,
    SD_BOTTOM = 4'b0100,
    SD_LEFT   = 4'b1000
  } side_t;

  logic [DIM_W-1:0] rows_r, cols_r;
  logic [DIM_W-1:0] rows_eff, cols_eff;
  logic [CNT_W-1:0] cnt_r, cnt_inc, total;

  logic signed [BND_W-1:0] top_r, bot_r, lft_r, rgt_r, i_r;
  logic signed [BND_W-1:0] top_nxt, bot_nxt, lft_nxt, rgt_nxt, i_nxt;
  side_t side_r, side_nxt;

  logic signed [BND_W-1:0] row_sel, col_sel;
  logic [CNT_W-1:0]        idx;
  logic                    last_step;
  logic                    valid_r, last_r;
  logic [DATA_W-1:0]       rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(MAX_DIM);
      cols_r <= DIM_W'(MAX_DIM);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_ROWS: rows_r <= cfg_data;
        CFG_NUM_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_eff = eff_dim(rows_r);
  assign cols_eff = eff_dim(cols_r);
  assign total    = CNT_W'(rows_eff) * CNT_W'(cols_eff);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign sts.load_full = (cnt_inc >= total);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= sts.load_full ? '0 : cnt_inc;
    end
  end

  // spiral walk
  always_comb begin
    row_sel = i_r;
    col_sel = i_r;
    case (side_r)
      SD_TOP:    row_sel = top_r;
      SD_RIGHT:  col_sel = rgt_r;
      SD_BOTTOM: row_sel = bot_r;
      SD_LEFT:   col_sel = lft_r;
      default: ;
    endcase
  end

  assign idx = CNT_W'(row_sel[POS_W-1:0]) * CNT_W'(cols_eff) + CNT_W'(col_sel[POS_W-1:0]);

  always_comb begin
    top_nxt   = top_r;
    bot_nxt   = bot_r;
    lft_nxt   = lft_r;
    rgt_nxt   = rgt_r;
    i_nxt     = i_r;
    side_nxt  = side_r;
    last_step = 1'b0;
    case (side_r)
      SD_TOP: begin
        if (i_r == rgt_r) begin
          top_nxt   = top_r + BND_W'(1);
          last_step = (top_r + BND_W'(1)) > bot_r;
          i_nxt     = top_r + BND_W'(1);
          side_nxt  = SD_RIGHT;
        end else begin
          i_nxt = i_r + BND_W'(1);
        end
      end
      SD_RIGHT: begin
        if (i_r == bot_r) begin
          rgt_nxt   = rgt_r - BND_W'(1);
          last_step = lft_r > (rgt_r - BND_W'(1));
          i_nxt     = rgt_r - BND_W'(1);
          side_nxt  = SD_BOTTOM;
        end else begin
          i_nxt = i_r + BND_W'(1);
        end
      end
      SD_BOTTOM: begin
        if (i_r == lft_r) begin
          bot_nxt   = bot_r - BND_W'(1);
          last_step = top_r > (bot_r - BND_W'(1));
          i_nxt     = bot_r - BND_W'(1);
          side_nxt  = SD_LEFT;
        end else begin
          i_nxt = i_r - BND_W'(1);
        end
      end
      SD_LEFT: begin
        if (i_r == top_r) begin
          lft_nxt   = lft_r + BND_W'(1);
          last_step = (lft_r + BND_W'(1)) > rgt_r;
          i_nxt     = lft_r + BND_W'(1);
          side_nxt  = SD_TOP;
        end else begin
          i_nxt = i_r - BND_W'(1);
        end
      end
      default: begin
        side_nxt = SD_TOP;
      end
    endcase
  end

  assign sts.scan_last = last_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SD_TOP;
    end else if (cmd.scan_init) begin
      side_r <= SD_TOP;
    end else if (cmd.scan_step) begin
      side_r <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      top_r <= '0;
      lft_r <= '0;
      i_r   <= '0;
      bot_r <= $signed(BND_W'(rows_eff)) - BND_W'(1);
      rgt_r <= $signed(BND_W'(cols_eff)) - BND_W'(1);
    end else if (cmd.scan_step) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      lft_r <= lft_nxt;
      rgt_r <= rgt_nxt;
      i_r   <= i_nxt;
    end
  end

  sos_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.load),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(in_elem_value),
    .raddr(idx[ADDR_W-1:0]),
    .rdata(rdata)
  );

  // read data is registered in the memory; valid and last are registered to match
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= cmd.scan_step;
      last_r  <= cmd.scan_step & last_step;
    end
  end

  assign out_valid = valid_r;
  assign out_last  = last_r;
  assign out_value = $signed(rdata);

endmodule

// ===== rtl/spiral_order_scan.sv =====
// channel   ports                                    transaction
// input     start, busy, in_elem_value               start & !busy
// result    out_valid, out_value, out_last           out_valid, one cycle each
// config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid & cfg_ready
//
// loading takes one element per cycle while busy is low; cfg_ready is always high
// the completing element starts a burst of rows*cols results, one per cycle,
// paced by the single read port of the element memory, whose read data is registered
// busy stays high through the burst and in the drain state after the last address
// rst_n is synchronous; element memory is not cleared, the counter and sizes are
// results cannot be stalled by the receiver
module spiral_order_scan import sos_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_elem_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  sos_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  sos_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_elem_value(in_elem_value),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_value    (out_value),
    .out_last     (out_last)
  );

endmodule

// ===== rtl/sos_checker.sv =====
`include "spiral_order_scan_assert.svh"

module sos_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  `SOS_ASSERT_NOW(a_last_has_valid, clk, rst_n, out_last, out_valid)
  `SOS_ASSERT_NOW(a_result_while_busy, clk, rst_n, out_valid, busy)
  `SOS_ASSERT_NEXT(a_burst_unbroken, clk, rst_n, out_valid && !out_last, out_valid)
  `SOS_ASSERT_NEXT(a_idle_after_last, clk, rst_n, out_last, !busy && !out_valid)

endmodule

bind spiral_order_scan sos_checker u_sos_checker (.*);

// ===== verif/testbench.sv =====
module testbench import sos_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 360;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [DATA_W-1:0] ELEM_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ELEM_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } spiral_elem_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] in_elem_value = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DIM_W-1:0]         cfg_data = '0;

  // scan model state
  logic [DATA_W-1:0] elem_mem [DEPTH];
  int                load_cnt = 0;
  logic [DIM_W-1:0]  dim_rows = DIM_W'(8);
  logic [DIM_W-1:0]  dim_cols = DIM_W'(8);
  spiral_elem_t      spiral_q [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_gap_max = 0;
  int random_sent = 0;

  spiral_order_scan dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_elem_value (in_elem_value),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return 1;
    end
    if (int'(d) > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(d);
  endfunction

  function automatic int matrix_size();
    return clamp_dim(dim_rows) * clamp_dim(dim_cols);
  endfunction

  function automatic void queue_elem(input logic [DATA_W-1:0] v);
    spiral_elem_t e;
    e.value = v;
    e.last  = 1'b0;
    spiral_q.insert(spiral_q.size(), e);
  endfunction

  function automatic void push_spiral(input int rows, input int cols);
    int top;
    int bot;
    int lft;
    int rgt;
    int i;
    int first;
    first = spiral_q.size();
    top = 0;
    bot = rows - 1;
    lft = 0;
    rgt = cols - 1;
    while (top <= bot && lft <= rgt) begin
      for (i = lft; i <= rgt; i++) queue_elem(elem_mem[(top * cols + i) % DEPTH]);
      top++;
      if (top > bot) break;
      for (i = top; i <= bot; i++) queue_elem(elem_mem[(i * cols + rgt) % DEPTH]);
      rgt--;
      if (lft > rgt) break;
      for (i = rgt; i >= lft; i--) queue_elem(elem_mem[(bot * cols + i) % DEPTH]);
      bot--;
      if (top > bot) break;
      for (i = bot; i >= top; i--) queue_elem(elem_mem[(i * cols + lft) % DEPTH]);
      lft++;
    end
    if (spiral_q.size() > first) begin
      spiral_q[spiral_q.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void load_elem(input logic [DATA_W-1:0] v);
    int rows;
    int cols;
    rows = clamp_dim(dim_rows);
    cols = clamp_dim(dim_cols);
    elem_mem[load_cnt % DEPTH] = v;
    load_cnt = (load_cnt + 1) % 128;
    if (load_cnt >= rows * cols) begin
      load_cnt = 0;
      push_spiral(rows, cols);
    end
  endfunction

  function automatic logic [DATA_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    if ($urandom_range(0, 4) == 0) begin
      return DIM_W'($urandom_range(0, 15));
    end
    return DIM_W'($urandom_range(1, MAX_DIM));
  endfunction

  task automatic send_elem(input logic [DATA_W-1:0] v);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_elem_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    load_elem(v);
  endtask

  // send until the current matrix completes
  task automatic send_matrix();
    do begin
      send_elem(rand_elem());
      random_sent++;
    end while (load_cnt != 0);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (spiral_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data,
                           input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_NUM_ROWS) begin
      dim_rows = data;
    end else if (idx == CFG_NUM_COLS) begin
      dim_cols = data;
    end
    if (!hold) begin
      cfg_valid <= 1'b0;
    end
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    drain_results();
    cfg_write(CFG_NUM_ROWS, rows, 1'b1);
    cfg_write(CFG_NUM_COLS, cols, 1'b0);
  endtask

  task automatic test_reset_size();
    sender_gap_max = 14;
    repeat (MAX_DIM * MAX_DIM) send_elem(rand_elem());
  endtask

  task automatic test_single_element();
    set_dims(DIM_W'(1), DIM_W'(1));
    // writes past the register list must leave the sizes alone
    cfg_write(CFG_SPARE_A, DIM_W'(15), 1'b1);
    cfg_write(CFG_SPARE_B, DIM_W'(4), 1'b0);
    sender_gap_max = 0;
    send_elem(ELEM_MIN);
    send_elem(ELEM_MAX);
  endtask

  task automatic test_single_row_saturated();
    set_dims(DIM_W'(0), DIM_W'(15));
    sender_gap_max = 3;
    send_elem('0);
    send_elem('1);
    send_elem(32'h5555_5555);
    send_elem(32'haaaa_aaaa);
    send_elem(32'h0000_0001);
    send_elem(ELEM_MIN);
    send_elem(ELEM_MAX);
    send_elem($urandom);
  endtask

  task automatic test_single_column_zero();
    set_dims(DIM_W'(3), DIM_W'(0));
    sender_gap_max = 14;
    repeat (3) send_elem($urandom);
  endtask

  task automatic test_shrink_mid_load();
    set_dims(DIM_W'(3), DIM_W'(3));
    sender_gap_max = 2;
    repeat (5) send_elem($urandom);
    set_dims(DIM_W'(2), DIM_W'(2));
    send_elem($urandom);
  endtask

  task automatic test_grow_mid_load();
    set_dims(DIM_W'(2), DIM_W'(2));
    sender_gap_max = 0;
    repeat (2) send_elem($urandom);
    set_dims(DIM_W'(2), DIM_W'(3));
    repeat (4) send_elem($urandom);
  endtask

  task automatic test_random_scans();
    int total;
    int partial;
    while (random_sent < RANDOM_ITEMS) begin
      set_dims(rand_dim(), rand_dim());
      sender_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      total = matrix_size();
      if ($urandom_range(0, 5) == 0 && total > 1) begin
        // resize in the middle of a load
        partial = $urandom_range(1, total - 1);
        repeat (partial) begin
          send_elem(rand_elem());
          random_sent++;
        end
        set_dims(rand_dim(), rand_dim());
        send_matrix();
      end else begin
        repeat ($urandom_range(1, 3)) send_matrix();
      end
    end
  endtask

  always @(posedge clk) begin
    spiral_elem_t exp_elem;
    if (rst_n && out_valid === 1'b1) begin
      if (spiral_q.size() == 0) begin
        $error("unexpected result transaction: out_value=%0h out_last=%0b", out_value, out_last);
        mismatch_count++;
      end else begin
        exp_elem = spiral_q.pop_front();
        if (out_value !== exp_elem.value) begin
          $error("out_value mismatch: expected %0h actual %0h", exp_elem.value, out_value);
          mismatch_count++;
        end
        if (out_last !== exp_elem.last) begin
          $error("out_last mismatch: expected %0b actual %0b", exp_elem.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_single_element();
    test_single_row_saturated();
    test_single_column_zero();
    test_shrink_mid_load();
    test_grow_mid_load();
    test_random_scans();
    drain_results();
    if (mismatch_count == 0 && spiral_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
